@@ design/aarm_pkg.sv @@
// ----------------------------------------------------------------------------
// aarm_pkg
// shared constants and types of the axis-angle rotation matrix unit
// ----------------------------------------------------------------------------
package aarm_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 16;

	// q30 values carry sign and some headroom
	localparam int QW = 34;
	localparam logic signed [QW-1:0] Q30_ONE = QW'(64'sd1 << 30);
	localparam logic signed [QW-1:0] CORDIC_GAIN = QW'(64'sd652032874);

	// square root: radicand is n2 * 2^30, n2 < 2^32
	localparam int RAD_W  = 62;
	localparam int ROOT_W = RAD_W / 2;
	// division: dividend |k| * 2^45, |k| <= 2^15
	localparam int DIVD_W = 61;
	localparam int QUO_W  = 46;

	localparam int N_SQRT = ROOT_W;
	localparam int N_DIV  = QUO_W;

	function automatic logic [31:0] atan_entry(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;  1: t = 32'd316933406;
			2: t = 32'd167458907;  3: t = 32'd85004756;
			4: t = 32'd42667331;   5: t = 32'd21354465;
			6: t = 32'd10680862;   7: t = 32'd5340245;
			8: t = 32'd2670163;    9: t = 32'd1335087;
			10: t = 32'd667544;    11: t = 32'd333772;
			12: t = 32'd166886;    13: t = 32'd83443;
			14: t = 32'd41721;     15: t = 32'd20860;
			16: t = 32'd10430;     17: t = 32'd5215;
			18: t = 32'd2607;      19: t = 32'd1303;
			20: t = 32'd651;       21: t = 32'd325;
			22: t = 32'd162;       23: t = 32'd81;
			24: t = 32'd40;        25: t = 32'd20;
			26: t = 32'd10;        27: t = 32'd5;
			28: t = 32'd2;         29: t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

	// round q30 product: floor((a*b + 2^29) / 2^30)
	function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [2*QW-1:0] p;
		p = a * b + (64'sd1 <<< 29);
		return QW'(p >>> 30);
	endfunction

	function automatic logic signed [15:0] to_field(input logic signed [QW+1:0] e);
		localparam int SH = 30 - FRAC_BITS;
		localparam logic signed [QW+1:0] ONE = (QW+2)'(64'sd1 <<< FRAC_BITS);
		localparam logic signed [QW+1:0] HI = (ONE > 32767) ? (QW+2)'(32767) : ONE;
		localparam logic signed [QW+1:0] LO = (ONE > 32768) ? -(QW+2)'(32768) : -ONE;
		logic signed [QW+1:0] v;
		v = e;
		if (SH > 0) v = (e + ((QW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
		if (v < LO) v = LO;
		if (v > HI) v = HI;
		return v[15:0];
	endfunction

	typedef logic signed [QW-1:0] q30_t;

endpackage

@@ design/aarm_norm.sv @@
// ----------------------------------------------------------------------------
// aarm_norm
// pipelined axis normalisation: square root then three restoring dividers,
// one bit per stage
// ----------------------------------------------------------------------------
module aarm_norm import aarm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic signed [15:0] az,
	output q30_t               ux,
	output q30_t               uy,
	output q30_t               uz
);

	localparam int NS = N_SQRT + 1;

	// square root pipeline
	logic [RAD_W-1:0]  sq_v_s   [NS];
	logic [ROOT_W+1:0] sq_r_s   [NS];
	logic [RAD_W+1:0]  sq_rem_s [NS];
	logic [15:0]       sq_m_s   [NS][3];
	logic              sq_n_s   [NS][3];

	logic [33:0] n2;
	assign n2 = 34'($signed(ax) * $signed(ax)) + 34'($signed(ay) * $signed(ay))
		+ 34'($signed(az) * $signed(az));

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0]   <= RAD_W'({n2, 30'd0});
			sq_r_s[0]   <= '0;
			sq_rem_s[0] <= '0;
			sq_m_s[0][0] <= ax[15] ? 16'(-ax) : ax;
			sq_m_s[0][1] <= ay[15] ? 16'(-ay) : ay;
			sq_m_s[0][2] <= az[15] ? 16'(-az) : az;
			sq_n_s[0][0] <= ax[15];
			sq_n_s[0][1] <= ay[15];
			sq_n_s[0][2] <= az[15];
		end
	end

	for (genvar g = 0; g < N_SQRT; g++) begin : g_sqrt
		logic [RAD_W+1:0] rem;
		logic [RAD_W+1:0] trial;
		always_comb begin
			rem   = {sq_rem_s[g][RAD_W-1:0],
				sq_v_s[g][RAD_W-1-2*g -: 2]};
			trial = {(RAD_W - ROOT_W - 2)'(0), sq_r_s[g], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_v_s[g+1] <= sq_v_s[g];
				sq_m_s[g+1] <= sq_m_s[g];
				sq_n_s[g+1] <= sq_n_s[g];
				if (rem >= trial) begin
					sq_rem_s[g+1] <= rem - trial;
					sq_r_s[g+1]   <= {sq_r_s[g][ROOT_W:0], 1'b1};
				end else begin
					sq_rem_s[g+1] <= rem;
					sq_r_s[g+1]   <= {sq_r_s[g][ROOT_W:0], 1'b0};
				end
			end
		end
	end

	// division pipelines, quotient bits msb first
	localparam int ND = N_DIV + 1;
	logic [ROOT_W-1:0]  dv_d_s   [ND];
	logic [QUO_W-1:0]   dv_n_s   [ND][3];
	logic [ROOT_W:0]    dv_rem_s [ND][3];
	logic [QUO_W-1:0]   dv_q_s   [ND][3];
	logic               dv_sg_s  [ND][3];

	logic [ROOT_W-1:0] root;
	assign root = sq_r_s[N_SQRT][ROOT_W-1:0];

	// dividend bits above QUO_W form the starting remainder, below the divisor
	// since the quotient fits QUO_W bits
	logic [DIVD_W-1:0] dvd [3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			dvd[k] = (DIVD_W'(sq_m_s[N_SQRT][k]) << 45) + DIVD_W'(root >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d_s[0] <= (root == '0) ? ROOT_W'(1) : root;
			for (int k = 0; k < 3; k++) begin
				dv_n_s[0][k]   <= dvd[k][QUO_W-1:0];
				dv_rem_s[0][k] <= (ROOT_W+1)'(dvd[k][DIVD_W-1:QUO_W]);
				dv_q_s[0][k]   <= '0;
				dv_sg_s[0][k]  <= sq_n_s[N_SQRT][k];
			end
		end
	end

	for (genvar g = 0; g < N_DIV; g++) begin : g_div
		for (genvar k = 0; k < 3; k++) begin : g_lane
			logic [ROOT_W+1:0] rem;
			always_comb rem = {dv_rem_s[g][k], dv_n_s[g][k][QUO_W-1-g]};
			always_ff @(posedge clk) begin
				if (en) begin
					dv_n_s[g+1][k]  <= dv_n_s[g][k];
					dv_sg_s[g+1][k] <= dv_sg_s[g][k];
					if (rem >= {2'b00, dv_d_s[g]}) begin
						dv_rem_s[g+1][k] <= (ROOT_W+1)'(rem - {2'b00, dv_d_s[g]});
						dv_q_s[g+1][k]   <= {dv_q_s[g][k][QUO_W-2:0], 1'b1};
					end else begin
						dv_rem_s[g+1][k] <= (ROOT_W+1)'(rem);
						dv_q_s[g+1][k]   <= {dv_q_s[g][k][QUO_W-2:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk) if (en) dv_d_s[g+1] <= dv_d_s[g];
	end

	// quotient clamped to one
	q30_t uq [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (dv_q_s[N_DIV][k] > QUO_W'(64'd1 << 30))
				uq[k] = Q30_ONE;
			else
				uq[k] = QW'(dv_q_s[N_DIV][k]);
			if (dv_sg_s[N_DIV][k]) uq[k] = -uq[k];
		end
	end
	assign ux = uq[0];
	assign uy = uq[1];
	assign uz = uq[2];

endmodule

@@ design/aarm_cordic.sv @@
// ----------------------------------------------------------------------------
// aarm_cordic
// pipelined rotation-mode cordic, one micro-rotation per stage, with delay
// line up to the normaliser latency
// ----------------------------------------------------------------------------
module aarm_cordic import aarm_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] angle_turn,
	output q30_t        c,
	output q30_t        s
);

	localparam int NC = CORDIC_STEPS + 1;
	// normaliser takes N_SQRT + N_DIV + 2 register stages
	localparam int PAD = N_SQRT + N_DIV + 2 - CORDIC_STEPS - 2;

	q30_t               x_s [NC];
	q30_t               y_s [NC];
	logic signed [33:0] z_s [NC];
	logic               f_s [NC];

	logic [31:0] a0;
	logic [31:0] a1;
	logic        flip;
	always_comb begin
		a0   = {angle_turn, 16'd0};
		flip = (a0[31:30] == 2'b01) || (a0[31:30] == 2'b10);
		a1   = flip ? a0 + 32'h8000_0000 : a0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= 34'($signed(a1));
			f_s[0] <= flip;
		end
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		localparam logic signed [33:0] T = 34'(atan_entry(g));
		q30_t dx, dy;
		assign dx = x_s[g] >>> g;
		assign dy = y_s[g] >>> g;
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[g+1] <= f_s[g];
				if (!z_s[g][33]) begin
					x_s[g+1] <= x_s[g] - dy;
					y_s[g+1] <= y_s[g] + dx;
					z_s[g+1] <= z_s[g] - T;
				end else begin
					x_s[g+1] <= x_s[g] + dy;
					y_s[g+1] <= y_s[g] - dx;
					z_s[g+1] <= z_s[g] + T;
				end
			end
		end
	end

	q30_t cx, cy;
	always_comb begin
		cx = f_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
		cy = f_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
		if (cx > Q30_ONE) cx = Q30_ONE;
		if (cx < -Q30_ONE) cx = -Q30_ONE;
		if (cy > Q30_ONE) cy = Q30_ONE;
		if (cy < -Q30_ONE) cy = -Q30_ONE;
	end

	q30_t c_s [PAD+1];
	q30_t s_s [PAD+1];
	always_ff @(posedge clk) begin
		if (en) begin
			c_s[0] <= cx;
			s_s[0] <= cy;
			for (int i = 0; i < PAD; i++) begin
				c_s[i+1] <= c_s[i];
				s_s[i+1] <= s_s[i];
			end
		end
	end
	assign c = c_s[PAD];
	assign s = s_s[PAD];

endmodule

@@ design/aarm_matrix.sv @@
// ----------------------------------------------------------------------------
// aarm_matrix
// rodrigues products in three register stages and output rounding
// ----------------------------------------------------------------------------
module aarm_matrix import aarm_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  q30_t             ux,
	input  q30_t             uy,
	input  q30_t             uz,
	input  q30_t             c,
	input  q30_t             s,
	input  logic             zero_in,
	output logic signed [15:0] m [9]
);

	// stage 1: pairwise products of the unit axis and sine terms
	q30_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, xs_s1, ys_s1, zs_s1, c_s1, t_s1;
	logic z_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= mulq(ux, ux); yy_s1 <= mulq(uy, uy); zz_s1 <= mulq(uz, uz);
			xy_s1 <= mulq(uy, ux); xz_s1 <= mulq(uz, ux); yz_s1 <= mulq(uz, uy);
			xs_s1 <= mulq(ux, s);  ys_s1 <= mulq(uy, s);  zs_s1 <= mulq(uz, s);
			c_s1  <= c;
			t_s1  <= Q30_ONE - c;
			z_s1  <= zero_in;
		end
	end

	// stage 2: scale by one minus cosine
	q30_t xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, xs_s2, ys_s2, zs_s2, c_s2;
	logic z_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= mulq(xx_s1, t_s1); yy_s2 <= mulq(yy_s1, t_s1);
			zz_s2 <= mulq(zz_s1, t_s1); xy_s2 <= mulq(xy_s1, t_s1);
			xz_s2 <= mulq(xz_s1, t_s1); yz_s2 <= mulq(yz_s1, t_s1);
			xs_s2 <= xs_s1; ys_s2 <= ys_s1; zs_s2 <= zs_s1;
			c_s2  <= c_s1;
			z_s2  <= z_s1;
		end
	end

	// stage 3: sums and rounding to the output format
	logic signed [QW+1:0] e [9];
	always_comb begin
		e[0] = (QW+2)'(c_s2) + (QW+2)'(xx_s2);
		e[1] = (QW+2)'(xy_s2) - (QW+2)'(zs_s2);
		e[2] = (QW+2)'(xz_s2) + (QW+2)'(ys_s2);
		e[3] = (QW+2)'(xy_s2) + (QW+2)'(zs_s2);
		e[4] = (QW+2)'(c_s2) + (QW+2)'(yy_s2);
		e[5] = (QW+2)'(yz_s2) - (QW+2)'(xs_s2);
		e[6] = (QW+2)'(xz_s2) - (QW+2)'(ys_s2);
		e[7] = (QW+2)'(yz_s2) + (QW+2)'(xs_s2);
		e[8] = (QW+2)'(c_s2) + (QW+2)'(zz_s2);
	end

	localparam logic signed [QW+1:0] IDENT = (QW+2)'(64'sd1 <<< 30);
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				if (z_s2)
					m[i] <= (i % 4 == 0) ? to_field(IDENT) : 16'sd0;
				else
					m[i] <= to_field(e[i]);
			end
		end
	end

endmodule

@@ design/axis_angle_rotation_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit
// rodrigues rotation matrix from an axis of any length and a binary angle
// ----------------------------------------------------------------------------
// the unit takes one item per clock while the output is not stalled and gives
// one 3x3 matrix per item in signed q1.14, in order. the latency is set by the
// bit-per-stage square root and division of the axis normaliser; the cordic
// runs alongside it and waits in a delay line. the whole pipe advances only
// when the output register is empty or being taken, so a stall at the output
// holds every stage and nothing is lost or repeated. an all-zero axis raises
// zero_axis and gives the identity matrix.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic [15:0]        angle_turn,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] row0_col0,
	output logic signed [15:0] row0_col1,
	output logic signed [15:0] row0_col2,
	output logic signed [15:0] row1_col0,
	output logic signed [15:0] row1_col1,
	output logic signed [15:0] row1_col2,
	output logic signed [15:0] row2_col0,
	output logic signed [15:0] row2_col1,
	output logic signed [15:0] row2_col2,
	output logic               zero_axis
);

	// normaliser stages, plus the three matrix stages
	localparam int LAT = N_SQRT + N_DIV + 2 + 3;

	logic en;
	// pipe moves unless a finished item sits unaccepted at the output
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// valid bits travel alongside the data
	logic v_q   [LAT];
	logic zf_q  [LAT-3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zf_q[0] <= (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
			for (int i = 1; i < LAT-3; i++) zf_q[i] <= zf_q[i-1];
		end
	end
	assign out_valid = v_q[LAT-1];

	q30_t ux, uy, uz, c, s;

	aarm_norm u_norm (
		.clk    (clk),
		.en     (en),
		.ax     (axis_x),
		.ay     (axis_y),
		.az     (axis_z),
		.ux     (ux),
		.uy     (uy),
		.uz     (uz)
	);

	aarm_cordic u_cordic (
		.clk        (clk),
		.en         (en),
		.angle_turn (angle_turn),
		.c          (c),
		.s          (s)
	);

	logic signed [15:0] m [9];

	aarm_matrix u_matrix (
		.clk     (clk),
		.en      (en),
		.ux      (ux),
		.uy      (uy),
		.uz      (uz),
		.c       (c),
		.s       (s),
		.zero_in (zf_q[LAT-4]),
		.m       (m)
	);

	// zero flag is registered alongside the matrix stages, zo_s1 to zo_s3
	logic zo_s1, zo_s2, zo_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			zo_s1 <= zf_q[LAT-4];
			zo_s2 <= zo_s1;
			zo_s3 <= zo_s2;
		end
	end
	assign zero_axis = zo_s3;

	assign row0_col0 = m[0];
	assign row0_col1 = m[1];
	assign row0_col2 = m[2];
	assign row1_col0 = m[3];
	assign row1_col1 = m[4];
	assign row1_col2 = m[5];
	assign row2_col0 = m[6];
	assign row2_col1 = m[7];
	assign row2_col2 = m[8];

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the axis-angle rotation matrix unit against its own predictor
// ----------------------------------------------------------------------------
// a driver feeds items from a queue of pending axis-angle pairs; each accepted
// item has its matrix worked out in q30 (integer square root, rounded
// division, rotation-mode cordic, rodrigues products) and queued. a monitor
// compares every taken matrix, field by field, with the oldest prediction.
// both sides idle at random, with a long stretch of no idling, and once the
// sender holds off until every matrix has come back.
// ----------------------------------------------------------------------------
module testbench;
	import aarm_pkg::*;

	typedef struct {
		logic signed [15:0] ax, ay, az;
		logic [15:0]        ang;
	} axis_item_t;

	typedef struct {
		logic signed [15:0] m [9];
		logic               zero;
	} matrix_t;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, out_stall = 1'b0;
	logic in_stall, out_valid;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic [15:0] angle_turn = '0;
	logic signed [15:0] row0_col0, row0_col1, row0_col2, row1_col0, row1_col1;
	logic signed [15:0] row1_col2, row2_col0, row2_col1, row2_col2;
	logic zero_axis;

	axis_item_t pending_items [$];
	matrix_t    expected_matrices [$];
	int  fail_count = 0;
	int  cycle = 0;
	int  items_sent = 0;
	bit  calm = 1'b0;      // long stretch with no idling
	bit  hold_off = 1'b0;  // sender waits until everything has come back
	bit  stim_done = 1'b0;

	always #2 clk = ~clk;

	axis_angle_rotation_matrix_unit dut (.*);

	// floor shift of a signed value
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q30(longint a, longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic signed [15:0] entry_of(longint e);
		longint v, one;
		one = 64'sd1 << FRAC_BITS;
		v = e;
		if (30 - FRAC_BITS > 0)
			v = (e + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		v = clip(clip(v, -one, one), -32768, 32767);
		return v[15:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unit_part(longint k, longint unsigned r);
		longint unsigned mag, q;
		mag = k < 0 ? -k : k;
		q = ((mag << 45) + (r >> 1)) / r;
		if (q > (64'd1 << 30)) q = 64'd1 << 30;
		return k < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic matrix_t rotation_of(axis_item_t it);
		matrix_t res;
		longint x, y, z, ux, uy, uz, zt, cx, cy, dx, dy, c, s, t, one;
		longint xy, xz, yz, xs, ys, zs;
		longint unsigned r;
		logic [31:0] a;
		bit flip;
		x = it.ax; y = it.ay; z = it.az;
		one = 64'sd1 << 30;
		if (x == 0 && y == 0 && z == 0) begin
			for (int i = 0; i < 9; i++)
				res.m[i] = (i % 4 == 0) ? 16'(clip(64'sd1 << FRAC_BITS, 0, 32767)) : '0;
			res.zero = 1'b1;
			return res;
		end
		r = int_sqrt(longint'(x * x + y * y + z * z) << 30);
		ux = unit_part(x, r); uy = unit_part(y, r); uz = unit_part(z, r);
		a = {it.ang, 16'h0};
		flip = (a[31:30] == 2'b01 || a[31:30] == 2'b10);
		if (flip) a += 32'h8000_0000;
		zt = longint'(signed'(a));
		cx = 652032874; cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = floor_shift(cy, i); dy = floor_shift(cx, i);
			if (zt >= 0) begin
				cx -= dx; cy += dy; zt -= longint'(atan_entry(i));
			end else begin
				cx += dx; cy -= dy; zt += longint'(atan_entry(i));
			end
		end
		if (flip) begin
			cx = -cx; cy = -cy;
		end
		c = clip(cx, -one, one);
		s = clip(cy, -one, one);
		t = one - c;
		xy = round_q30(round_q30(uy, ux), t);
		xz = round_q30(round_q30(uz, ux), t);
		yz = round_q30(round_q30(uz, uy), t);
		xs = round_q30(ux, s); ys = round_q30(uy, s); zs = round_q30(uz, s);
		res.m[0] = entry_of(c + round_q30(round_q30(ux, ux), t));
		res.m[1] = entry_of(xy - zs);
		res.m[2] = entry_of(xz + ys);
		res.m[3] = entry_of(xy + zs);
		res.m[4] = entry_of(c + round_q30(round_q30(uy, uy), t));
		res.m[5] = entry_of(yz - xs);
		res.m[6] = entry_of(xz - ys);
		res.m[7] = entry_of(yz + xs);
		res.m[8] = entry_of(c + round_q30(round_q30(uz, uz), t));
		res.zero = 1'b0;
		return res;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 34);
	endfunction

	task automatic add_item(int x, int y, int z, int ang);
		axis_item_t it;
		it.ax = 16'(x); it.ay = 16'(y); it.az = 16'(z); it.ang = 16'(ang);
		pending_items.push_back(it);
	endtask

	// random axis component: full range, small, or edge values
	function automatic int pick_comp();
		case ($urandom_range(5))
			0: return $urandom_range(2) - 1;
			1: return $urandom_range(1) ? 32767 : -32768;
			2: return int'($urandom_range(64)) - 32;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	// driver: payload holds while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_matrices.push_back(rotation_of('{axis_x, axis_y, axis_z, angle_turn}));
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && !hold_off && !idle_now()) begin
					axis_item_t it;
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					axis_x <= it.ax; axis_y <= it.ay; axis_z <= it.az;
					angle_turn <= it.ang;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				logic signed [15:0] got [9];
				matrix_t want;
				got = '{row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
					row1_col2, row2_col0, row2_col1, row2_col2};
				if (expected_matrices.size() == 0) begin
					$error("matrix with no item pending");
					fail_count++;
				end else begin
					want = expected_matrices.pop_front();
					for (int i = 0; i < 9; i++)
						if (got[i] !== want.m[i]) begin
							$error("row%0d_col%0d expected %0d got %0d", i / 3, i % 3,
								want.m[i], got[i]);
							fail_count++;
						end
					if (zero_axis !== want.zero) begin
						$error("zero_axis expected %0d got %0d", want.zero, zero_axis);
						fail_count++;
					end
				end
			end
			out_stall <= idle_now();
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle++;
		if (cycle > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// directed: zero axis, extremes, cardinal axes and quadrant angles
		add_item(0, 0, 0, 0);
		add_item(0, 0, 0, 16'hffff);
		add_item(32767, 0, 0, 16384);
		add_item(0, -32768, 0, 32768);
		add_item(0, 0, 1, 49152);
		add_item(-32768, -32768, -32768, 16'h7fff);
		add_item(32767, 32767, 32767, 16'h8000);
		add_item(-1, 1, -1, 16'h3fff);
		add_item(1, 0, 0, 16'h4000);
		add_item(-32768, 32767, 1, 16'hc000);
		add_item(12345, -23456, 7, 16'h5555);
		add_item(0, 0, -32768, 16'haaaa);
		add_item(3, 4, 0, 8192);
		add_item(0, 0, 0, 16'h1234);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < 1750; n++)
			add_item(pick_comp(), pick_comp(), pick_comp(),
				($urandom_range(7) == 0) ? 16'({$urandom_range(3), 14'h0}) :
				$urandom_range(65535));
		// let some drain at random rates, then hold off until empty
		wait (pending_items.size() < 1300);
		@(posedge clk);
		hold_off <= 1'b1;
		wait (expected_matrices.size() == 0 && !out_valid);
		@(posedge clk);
		hold_off <= 1'b0;
		wait (pending_items.size() < 900);
		@(posedge clk);
		calm <= 1'b1;
		wait (pending_items.size() < 600);
		@(posedge clk);
		calm <= 1'b0;
		wait (pending_items.size() == 0);
		@(posedge clk);
		while (in_valid) @(posedge clk);
		wait (expected_matrices.size() == 0);
		repeat (N_SQRT + N_DIV + 20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
